// ===== rtl/look_at_view_matrix_macros.svh =====
// Assertion macros used by the port-level checker of the look-at view matrix block.
// No dependencies.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH
// Check that a condition implies a property on the next edge.
`define LAVM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("lavm check failed");
// Check that a condition implies a property on the same edge.
`define LAVM_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("lavm check failed");
`endif

// ===== rtl/lavm_pkg.sv =====
// Types, constants and rounding helpers of the look-at view matrix block.
// No dependencies.
package lavm_pkg;
	localparam int unsigned InW    = 32;
	localparam int unsigned AxisW  = 18;
	localparam int unsigned OffW   = 32;
	localparam int unsigned QW     = 16;
	localparam int unsigned SqrtSteps = 32;
	localparam int unsigned DivBits   = 18;
	localparam logic signed [AxisW-1:0] OneQ = 18'sd65536;

	typedef logic signed [AxisW-1:0] axis_t;
	typedef logic signed [OffW-1:0]  off_t;
	typedef axis_t vec_t [3];

	// Clamp a value to [-1, 1] in Q2.16.
	function automatic axis_t clamp_unit(input logic signed [67:0] v);
		if (v > 68'sd65536) return OneQ;
		if (v < -68'sd65536) return -OneQ;
		return v[AxisW-1:0];
	endfunction

	// Round an exact Q32 value to Q16.16, half away from zero.
	function automatic logic signed [67:0] round_q32(input logic signed [67:0] v);
		logic [67:0] m;
		m = v[67] ? 68'(-v) : 68'(v);
		m = (m + 68'd32768) >> QW;
		return v[67] ? -$signed(m) : $signed(m);
	endfunction

	function automatic off_t sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647) return 32'sh7fffffff;
		if (v < -68'sd2147483648) return 32'sh80000000;
		return v[OffW-1:0];
	endfunction
endpackage

// ===== rtl/lavm_norm.sv =====
// Pipelined 3-vector normalizer: scale, square sum, square root, divides.
// Depends on lavm_pkg. One vector may enter every cycle.
module lavm_norm import lavm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [51:0]  vx,
	input  logic signed [51:0]  vy,
	input  logic signed [51:0]  vz,
	output logic                out_valid,
	output logic                out_zero,
	output axis_t               nx,
	output axis_t               ny,
	output axis_t               nz
);
	logic [50:0] mag [3];
	logic [50:0] mx;
	logic [5:0]  lz;
	always_comb begin
		mag[0] = vx[51] ? 51'(-vx) : vx[50:0];
		mag[1] = vy[51] ? 51'(-vy) : vy[50:0];
		mag[2] = vz[51] ? 51'(-vz) : vz[50:0];
		mx = mag[0] | mag[1] | mag[2];
		lz = 6'd0;
		for (int i = 0; i < 51; i++)
			if (mx[i]) lz = 6'(i);
	end

	// stage 1: magnitudes, signs, highest set bit of the or-ed magnitudes
	logic [50:0] m_s1 [3];
	logic [2:0]  sg_s1;
	logic [5:0]  hb_s1;
	logic        z_s1, v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		m_s1  <= mag;
		sg_s1 <= {vz[51], vy[51], vx[51]};
		hb_s1 <= lz;
		z_s1  <= (mx == '0);
	end

	// stage 2: common shift so the largest lies in [2^29, 2^30)
	logic [29:0] sc [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (hb_s1 >= 6'd29) sc[i] = 30'(m_s1[i] >> (hb_s1 - 6'd29));
			else sc[i] = 30'(m_s1[i] << (6'd29 - hb_s1));
		end
	end
	logic [29:0] m_s2 [3];
	logic [2:0]  sg_s2;
	logic        z_s2, v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		m_s2 <= sc; sg_s2 <= sg_s1; z_s2 <= z_s1;
	end

	// stage 3: squares and sum
	logic [61:0] sum_s3;
	logic [29:0] m_s3 [3];
	logic [2:0]  sg_s3;
	logic        z_s3, v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		sum_s3 <= 62'(m_s2[0] * m_s2[0]) + 62'(m_s2[1] * m_s2[1]) + 62'(m_s2[2] * m_s2[2]);
		m_s3 <= m_s2; sg_s3 <= sg_s2; z_s3 <= z_s2;
	end

	// square root: one result bit per stage
	logic [63:0] rx [SqrtSteps+1];
	logic [63:0] rr [SqrtSteps+1];
	logic [29:0] rm [SqrtSteps+1][3];
	logic [2:0]  rs [SqrtSteps+1];
	logic        rz [SqrtSteps+1];
	logic        rv [SqrtSteps+1];
	always_comb begin
		rx[0] = {2'b00, sum_s3}; rr[0] = '0; rm[0] = m_s3;
		rs[0] = sg_s3; rz[0] = z_s3; rv[0] = v_s3;
	end
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		localparam int unsigned Sh = 2 * (SqrtSteps - 1 - k);
		logic [63:0] bit_v, trial;
		always_comb begin
			bit_v = 64'd1 << Sh;
			trial = rr[k] + bit_v;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[k+1] <= 1'b0;
			else rv[k+1] <= rv[k];
		end
		always_ff @(posedge clk) begin
			if (rx[k] >= trial) begin
				rx[k+1] <= rx[k] - trial;
				rr[k+1] <= (rr[k] >> 1) + bit_v;
			end else begin
				rx[k+1] <= rx[k];
				rr[k+1] <= rr[k] >> 1;
			end
			rm[k+1] <= rm[k]; rs[k+1] <= rs[k]; rz[k+1] <= rz[k];
		end
	end

	// divides: restoring, one quotient bit per stage, three lanes
	logic [31:0] len;
	assign len = rr[SqrtSteps][31:0];
	logic [47:0] dn [DivBits+1][3];
	logic [DivBits-1:0] dq [DivBits+1][3];
	logic [31:0] dl [DivBits+1];
	logic [2:0]  ds [DivBits+1];
	logic        dz [DivBits+1];
	logic        dv [DivBits+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv[0] <= 1'b0;
		else dv[0] <= rv[SqrtSteps];
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dn[0][i] <= {2'b00, rm[SqrtSteps][i], 16'd0} + 48'(len >> 1);
			dq[0][i] <= '0;
		end
		dl[0] <= len; ds[0] <= rs[SqrtSteps]; dz[0] <= rz[SqrtSteps];
	end
	for (genvar k = 0; k < DivBits; k++) begin : g_div
		localparam int unsigned Sh = DivBits - 1 - k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else dv[k+1] <= dv[k];
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if ((dn[k][i] >> Sh) >= {16'd0, dl[k]}) begin
					dn[k+1][i] <= dn[k][i] - ({16'd0, dl[k]} << Sh);
					dq[k+1][i] <= dq[k][i] | (DivBits'(1) << Sh);
				end else begin
					dn[k+1][i] <= dn[k][i];
					dq[k+1][i] <= dq[k][i];
				end
			end
			dl[k+1] <= dl[k]; ds[k+1] <= ds[k]; dz[k+1] <= dz[k];
		end
	end

	axis_t res [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dq[DivBits][i] > 18'd65536) res[i] = OneQ;
			else res[i] = $signed(dq[DivBits][i]);
			if (ds[DivBits][i]) res[i] = -res[i];
		end
	end
	assign out_valid = dv[DivBits];
	assign out_zero  = dz[DivBits];
	assign nx = res[0];
	assign ny = res[1];
	assign nz = res[2];
endmodule

// ===== rtl/lavm_delay.sv =====
// Fixed-length delay line for side data that travels past a normalizer.
// No dependencies beyond its parameters.
module lavm_delay #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4
) (
	input  logic             clk,
	input  logic [Width-1:0] d,
	output logic [Width-1:0] q
);
	logic [Width-1:0] tap_q [Depth];
	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < Depth; i++) tap_q[i] <= tap_q[i-1];
	end
	assign q = tap_q[Depth-1];
endmodule

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix: three rows per request, strobed on row_valid.
// The first row follows the accepting edge through two 54-stage normalizers,
// the cross stage, three offset stages and the row register; rows follow back to back.
// A new request is accepted only while busy is low, which keeps pace with the three-row output serializer.
// busy is high after each accepted request until the busy counter runs out; rows cannot be held off.
// Reset (arst_n low) clears all valid bits and the serializer; payload is not reset.
module look_at_view_matrix import lavm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x, eye_y, eye_z,
	input  logic signed [31:0] center_x, center_y, center_z,
	input  logic signed [31:0] up_x, up_y, up_z,
	output logic               row_valid,
	output axis_t              axis_x, axis_y, axis_z,
	output off_t               offset,
	output logic               degenerate,
	output logic               last
);
	localparam int unsigned NL = 3 + SqrtSteps + 1 + DivBits + 1;
	logic [1:0] cnt_q;
	logic acc;
	assign busy = (cnt_q != 2'd0);
	assign acc  = start && !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else if (acc) cnt_q <= 2'd2;
		else if (cnt_q != 2'd0) cnt_q <= cnt_q - 2'd1;
	end

	// forward normalize
	logic fv, fz;
	axis_t f [3];
	lavm_norm u_nf (
		.clk(clk), .arst_n(arst_n), .in_valid(acc),
		.vx(52'(center_x) - 52'(eye_x)), .vy(52'(center_y) - 52'(eye_y)),
		.vz(52'(center_z) - 52'(eye_z)),
		.out_valid(fv), .out_zero(fz), .nx(f[0]), .ny(f[1]), .nz(f[2])
	);
	logic [191:0] eu_d;
	lavm_delay #(.Width(192), .Depth(NL-1)) u_d1 (
		.clk(clk), .d({eye_x, eye_y, eye_z, up_x, up_y, up_z}), .q(eu_d));

	// cross f x up
	logic signed [31:0] upv [3];
	assign upv[0] = eu_d[95:64]; assign upv[1] = eu_d[63:32]; assign upv[2] = eu_d[31:0];
	logic signed [51:0] c_s1 [3];
	logic cv_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_s1 <= 1'b0;
		else cv_s1 <= fv;
	end
	always_ff @(posedge clk) begin
		c_s1[0] <= 52'(f[1] * upv[2]) - 52'(f[2] * upv[1]);
		c_s1[1] <= 52'(f[2] * upv[0]) - 52'(f[0] * upv[2]);
		c_s1[2] <= 52'(f[0] * upv[1]) - 52'(f[1] * upv[0]);
	end
	logic sv, sz;
	axis_t s [3];
	lavm_norm u_ns (
		.clk(clk), .arst_n(arst_n), .in_valid(cv_s1),
		.vx(c_s1[0]), .vy(c_s1[1]), .vz(c_s1[2]),
		.out_valid(sv), .out_zero(sz), .nx(s[0]), .ny(s[1]), .nz(s[2])
	);
	logic [150:0] fd;
	lavm_delay #(.Width(151), .Depth(NL)) u_d2 (
		.clk(clk), .d({fz, f[0], f[1], f[2], eu_d[191:96]}), .q(fd));
	axis_t fdv [3];
	logic signed [31:0] ev [3];
	assign fdv[0] = fd[149:132]; assign fdv[1] = fd[131:114]; assign fdv[2] = fd[113:96];
	assign ev[0] = fd[95:64]; assign ev[1] = fd[63:32]; assign ev[2] = fd[31:0];

	// stage a: u = s x f exact, products for dot terms
	logic signed [67:0] ux_a [3], sd_a [3], fd_a [3];
	axis_t sa [3], fa [3];
	logic signed [31:0] ea [3];
	logic va, dga;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va <= 1'b0;
		else va <= sv;
	end
	always_ff @(posedge clk) begin
		ux_a[0] <= 68'(s[1] * fdv[2]) - 68'(s[2] * fdv[1]);
		ux_a[1] <= 68'(s[2] * fdv[0]) - 68'(s[0] * fdv[2]);
		ux_a[2] <= 68'(s[0] * fdv[1]) - 68'(s[1] * fdv[0]);
		for (int i = 0; i < 3; i++) begin
			sd_a[i] <= 68'(s[i] * ev[i]);
			fd_a[i] <= 68'(fdv[i] * ev[i]);
		end
		sa <= s; fa <= fdv; ea <= ev;
		dga <= sz || fd[150];
	end
	// stage b: round u, u products
	axis_t ub [3], sb [3], fb [3];
	logic signed [67:0] sdb, fdb, udp_b [3];
	logic vb, dgb;
	always_comb begin
		for (int i = 0; i < 3; i++) ub[i] = clamp_unit(round_q32(ux_a[i]));
	end
	axis_t ubr [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb <= 1'b0;
		else vb <= va;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) udp_b[i] <= 68'(ub[i] * ea[i]);
		ubr <= ub; sb <= sa; fb <= fa;
		sdb <= sd_a[0] + sd_a[1] + sd_a[2];
		fdb <= fd_a[0] + fd_a[1] + fd_a[2];
		dgb <= dga;
	end
	// stage c: offsets
	off_t o_c [3];
	axis_t uc [3], sc [3], fc [3];
	logic vc, dgc;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc <= 1'b0;
		else vc <= vb;
	end
	always_ff @(posedge clk) begin
		o_c[0] <= sat32(-round_q32(sdb));
		o_c[1] <= sat32(-round_q32(udp_b[0] + udp_b[1] + udp_b[2]));
		o_c[2] <= sat32(round_q32(fdb));
		uc <= ubr; sc <= sb; fc <= fb; dgc <= dgb;
	end

	// serializer: three rows, one per cycle
	logic [1:0] row_q;
	off_t o_q [3];
	axis_t r_q [3][3];
	logic dg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) row_q <= 2'd0;
		else if (vc) row_q <= 2'd1;
		else if (row_q == 2'd3) row_q <= 2'd0;
		else if (row_q != 2'd0) row_q <= row_q + 2'd1;
	end
	always_ff @(posedge clk) begin
		if (vc) begin
			r_q[0] <= sc; r_q[1] <= uc;
			r_q[2][0] <= -fc[0]; r_q[2][1] <= -fc[1]; r_q[2][2] <= -fc[2];
			o_q <= o_c; dg_q <= dgc;
		end
	end
	logic [1:0] ri;
	assign ri = (row_q == 2'd0) ? 2'd0 : row_q - 2'd1;
	assign row_valid  = (row_q != 2'd0);
	assign degenerate = dg_q;
	assign last       = (row_q == 2'd3);
	assign axis_x = dg_q ? '0 : r_q[ri][0];
	assign axis_y = dg_q ? '0 : r_q[ri][1];
	assign axis_z = dg_q ? '0 : r_q[ri][2];
	assign offset = dg_q ? '0 : o_q[ri];
endmodule

// ===== rtl/lavm_checker.sv =====
// Port-level checks of the look-at view matrix block, bound to the top level.
// Depends on look_at_view_matrix_macros.svh.
`include "look_at_view_matrix_macros.svh"
module lavm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic row_valid,
	input logic last,
	input logic degenerate
);
	`LAVM_ASSERT_NEXT(a_busy_after_req, clk, arst_n, start && !busy, busy)
	`LAVM_ASSERT_NOW(a_last_valid, clk, arst_n, last, row_valid)
	`LAVM_ASSERT_NEXT(a_row_after_last, clk, arst_n, row_valid && !last, row_valid && (degenerate == $past(degenerate)))
endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.row_valid(row_valid), .last(last), .degenerate(degenerate)
);

// ===== test/look_at_view_matrix_checker.sv =====
// Row checker for the look-at view matrix block: predicts the three matrix rows
// of every accepted request and compares them with the strobed rows.
// Depends on lavm_pkg for the axis and offset types.
`timescale 1ns / 100ps
module look_at_view_matrix_checker import lavm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] eye_x, eye_y, eye_z,
	input  logic signed [31:0] center_x, center_y, center_z,
	input  logic signed [31:0] up_x, up_y, up_z,
	input  logic               row_valid,
	input  axis_t              axis_x, axis_y, axis_z,
	input  off_t               offset,
	input  logic               degenerate,
	input  logic               last,
	output int                 errors,
	output int                 pending,
	output int                 rows_seen,
	output int                 degen_seen
);
	typedef struct packed {
		axis_t ax, ay, az;
		off_t  off;
		logic  degen;
		logic  lst;
	} row_t;

	typedef logic signed [67:0] wide_t;

	row_t rows_due[$];

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic wide_t mag(input wide_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic wide_t limit_unit(input wide_t v);
		if (v > 65536) return 65536;
		if (v < -65536) return -65536;
		return v;
	endfunction

	function automatic wide_t to_q16(input wide_t v);
		wide_t m;
		m = (mag(v) + 32768) >>> 16;
		return v < 0 ? -m : m;
	endfunction

	function automatic wide_t saturate(input wide_t v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Scale so the largest magnitude lies in [2^29, 2^30), then divide by the length.
	function automatic logic unit_vec(input wide_t v[3], output wide_t o[3]);
		logic [63:0] m[3];
		logic [63:0] mx, sum, len, q;
		int rs, ls;
		mx = 0;
		sum = 0;
		rs = 0;
		ls = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = 64'(mag(v[i]));
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return 1'b0;
		while (mx >= (64'd1 << 30)) begin mx >>= 1; rs++; end
		while (mx < (64'd1 << 29)) begin mx <<= 1; ls++; end
		for (int i = 0; i < 3; i++) begin
			m[i] = (m[i] >> rs) << ls;
			sum += m[i] * m[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd65536 + len / 2) / len;
			o[i] = limit_unit(v[i] < 0 ? -wide_t'(q) : wide_t'(q));
		end
		return 1'b1;
	endfunction

	function automatic void cross_prod(input wide_t a[3], input wide_t b[3],
		output wide_t r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic wide_t eye_dot(input wide_t a[3], input wide_t e[3]);
		return to_q16(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
	endfunction

	task automatic predict_rows();
		wide_t eye[3], up[3], dir[3], fwd[3], c[3], side[3], tup[3];
		wide_t ax[3][3], off[3];
		logic ok;
		row_t r;
		eye = '{eye_x, eye_y, eye_z};
		up = '{up_x, up_y, up_z};
		dir = '{wide_t'(center_x) - eye_x, wide_t'(center_y) - eye_y,
			wide_t'(center_z) - eye_z};
		ok = unit_vec(dir, fwd);
		if (ok) begin
			cross_prod(fwd, up, c);
			ok = unit_vec(c, side);
		end
		if (ok) begin
			cross_prod(side, fwd, c);
			for (int i = 0; i < 3; i++) begin
				tup[i] = limit_unit(to_q16(c[i]));
				ax[0][i] = side[i];
				ax[1][i] = tup[i];
				ax[2][i] = -fwd[i];
			end
			off[0] = saturate(-eye_dot(side, eye));
			off[1] = saturate(-eye_dot(tup, eye));
			off[2] = saturate(eye_dot(fwd, eye));
		end
		for (int k = 0; k < 3; k++) begin
			r.ax = ok ? axis_t'(ax[k][0]) : '0;
			r.ay = ok ? axis_t'(ax[k][1]) : '0;
			r.az = ok ? axis_t'(ax[k][2]) : '0;
			r.off = ok ? off_t'(off[k]) : '0;
			r.degen = !ok;
			r.lst = (k == 2);
			rows_due.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		row_t want, got;
		if (!arst_n) begin
			rows_due.delete();
			errors = 0;
			rows_seen = 0;
			degen_seen = 0;
		end else begin
			if (row_valid) begin
				got = '{axis_x, axis_y, axis_z, offset, degenerate, last};
				rows_seen++;
				if (degenerate) degen_seen++;
				if (rows_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected row: %p", got);
				end else begin
					want = rows_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("row mismatch: expected %p got %p", want, got);
					end
				end
			end
			if (start && !busy) predict_rows();
		end
		pending = rows_due.size();
	end
endmodule

// ===== test/tb_look_at_view_matrix.sv =====
// Testbench top for the look-at view matrix block: drives directed and random camera
// requests in bursts and gives the verdict. Depends on lavm_pkg, the block and the checker.
`timescale 1ns / 100ps
module tb_look_at_view_matrix import lavm_pkg::*;;

	localparam int Latency = 2 * 55 + 5 + 10;
	localparam int WatchLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, row_valid, degenerate, last;
	logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [31:0] center_x = 0, center_y = 0, center_z = 0;
	logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
	axis_t axis_x, axis_y, axis_z;
	off_t offset;
	int errors, pending, rows_seen, degen_seen;
	int idle_cycles = 0;
	int requests = 0;

	always #1 clk = ~clk;

	look_at_view_matrix dut (.*);
	look_at_view_matrix_checker chk (.*);

	// Count cycles with no traffic; a hang ends the run.
	always @(posedge clk) begin
		if ((start && !busy) || row_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_coord(input int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 20)) - 10 <<< 16;
			2: return $signed($urandom_range(0, 2000000)) - 1000000;
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	// Hold a request on the ports until it is accepted; start stays high afterwards.
	task automatic send(input logic signed [31:0] v[9]);
		eye_x <= v[0]; eye_y <= v[1]; eye_z <= v[2];
		center_x <= v[3]; center_y <= v[4]; center_z <= v[5];
		up_x <= v[6]; up_y <= v[7]; up_z <= v[8];
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		requests++;
	endtask

	// Drop start and wait until every predicted row has come out.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random();
		logic signed [31:0] v[9];
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++)
			v[i] = rand_coord(kind < 4 ? 1 : kind < 7 ? 2 : kind < 9 ? 0 : $urandom_range(0, 3));
		// make some requests degenerate on purpose
		case ($urandom_range(0, 19))
			0: begin v[3] = v[0]; v[4] = v[1]; v[5] = v[2]; end
			1: begin v[6] = v[3] - v[0]; v[7] = v[4] - v[1]; v[8] = v[5] - v[2]; end
			2: begin v[6] = 0; v[7] = 0; v[8] = 0; end
			default: ;
		endcase
		send(v);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// plain camera, eye equals target, up along forward, zero up, extremes
		send('{0, 0, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0});
		send('{32'sh30000, 32'sh20000, 32'sh10000, 32'sh30000, 32'sh20000, 32'sh10000,
			0, 32'sh10000, 0});
		send('{0, 0, 0, 32'sh10000, 0, 0, 32'sh40000, 0, 0});
		send('{0, 0, 0, 0, 32'sh10000, 0, 0, 0, 0});
		send('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0});
		send('{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
		send('{32'sh7fffffff, 0, 32'sh80000000, 0, 32'sh7fffffff, 0, 1, -1, 1});
		send('{-1, -1, -1, 0, 0, 0, -1, 0, 1});
		send('{32'sh55555555, 32'shaaaaaaaa, 32'sh12345678, -32'sh12345678, 32'sh0f0f0f0f,
			32'shf0f0f0f0, 32'sh7fff0000, 32'sh00010001, -32'sh10000});
		send('{0, 0, 0, 1, 0, 0, 0, 1, 0});
		// drain fully before the random part
		drain();
		repeat (Latency) @(posedge clk);
		for (int burst = 0; requests < 150; burst++) begin
			int len;
			int gap;
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) send_random();
			if (burst == 5) begin
				drain();
			end else if (burst % 4 != 3) begin
				gap = $urandom_range(1, 20);
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		start <= 1'b0;
		@(posedge clk);
		for (int n = 0; pending != 0 && n < 10000; n++) @(posedge clk);
		repeat (Latency) @(posedge clk);
		$display("%0d requests, %0d rows checked, %0d degenerate rows", requests,
			rows_seen, degen_seen);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lavm_pkg.sv
rtl/lavm_norm.sv
rtl/lavm_delay.sv
rtl/look_at_view_matrix.sv
rtl/lavm_checker.sv
test/look_at_view_matrix_checker.sv
test/tb_look_at_view_matrix.sv
